[design/av1_syntax_element_reader_unit_assert.svh]
// Assertion macros for the syntax element reader
`ifndef AV1_SYNTAX_ELEMENT_READER_UNIT_ASSERT_SVH
`define AV1_SYNTAX_ELEMENT_READER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define AVR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define AVR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/avr_pkg.sv]
package avr_pkg;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_F       = 3'd1,
		OP_SU      = 3'd2,
		OP_NS      = 3'd3,
		OP_LE      = 3'd4,
		OP_UVLC    = 3'd5,
		OP_LEB     = 3'd6,
		OP_RESTART = 3'd7
	} avr_op_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNDER  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADARG = 2'd3;

	localparam int WIN_BITS = 64;

	typedef struct packed {
		logic load;
		logic calc;
		logic apply;
	} avr_cmd_t;

	// Leading zero count of a 32-bit word, 32 when all zero
	function automatic logic [5:0] clz32(input logic [31:0] w);
		logic [5:0] c;
		logic       hit;
		c   = 6'd32;
		hit = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!hit && w[i]) begin
				c   = 6'(31 - i);
				hit = 1'b1;
			end
		end
		return c;
	endfunction

	// n bits of the window starting pos bits from its top, right aligned
	function automatic logic [63:0] peek64(input logic [63:0] w, input logic [6:0] pos,
		input logic [6:0] n);
		logic [63:0] t;
		t = w << pos;
		if (n == 7'd0)
			return 64'd0;
		return t >> (7'd64 - n);
	endfunction

endpackage

[design/avr_ctrl.sv]
module avr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output avr_pkg::avr_cmd_t cmd
);
	import avr_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_APPLY, S_OUT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			s_tready <= 1'b1;
			m_tvalid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q  <= S_CALC;
						s_tready <= 1'b0;
					end
				end
				S_CALC: state_q <= S_APPLY;
				S_APPLY: begin
					state_q  <= S_OUT;
					m_tvalid <= 1'b1;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q  <= S_IDLE;
						m_tvalid <= 1'b0;
						s_tready <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.load  = s_tvalid && s_tready;
	assign cmd.calc  = (state_q == S_CALC);
	assign cmd.apply = (state_q == S_APPLY);

endmodule

[design/avr_dp.sv]
module avr_dp #(
	parameter int BUFFER_BITS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  avr_pkg::avr_cmd_t cmd,
	input  logic [2:0]        in_opcode,
	input  logic [7:0]        in_byte,
	input  logic [31:0]       in_arg,
	output logic [56:0]       res_value,
	output logic [3:0]        res_len,
	output logic [1:0]        res_status,
	output logic [31:0]       res_pos
);
	import avr_pkg::*;

	localparam int FW = $clog2(BUFFER_BITS + 1);

	logic [2:0]             op_q;
	logic [7:0]             byte_q;
	logic [31:0]            arg_q;
	logic [BUFFER_BITS-1:0] buf_q;
	logic [FW-1:0]          fill_q;
	logic [31:0]            cons_q;
	logic [6:0]             take_q;
	logic                   push_ok_q;

	logic [63:0] front;
	logic [31:0] fill32;
	logic [63:0] val;
	logic [3:0]  len;
	logic [1:0]  st;
	logic [6:0]  take;
	logic [63:0] v;
	logic [63:0] m;
	logic [6:0]  n;
	logic [6:0]  w;
	logic [5:0]  c;
	logic [5:0]  lz;
	logic [7:0]  b;
	logic        stop;
	logic        done;
	logic [3:0]  cnt;
	logic [FW-1:0] shv;

	assign front  = buf_q[BUFFER_BITS-1 -: WIN_BITS];
	assign fill32 = 32'(fill_q);
	assign shv    = FW'(BUFFER_BITS - 8) - fill_q;

	always_comb begin
		val  = 64'd0;
		len  = 4'd0;
		st   = ST_OK;
		take = 7'd0;
		v    = 64'd0;
		m    = 64'd0;
		n    = 7'd0;
		w    = 7'd0;
		c    = 6'd0;
		lz   = 6'd0;
		b    = 8'd0;
		stop = 1'b0;
		done = 1'b0;
		cnt  = 4'd0;
		case (op_q)
			OP_PUSH: begin
				if (fill32 + 32'd8 > 32'(BUFFER_BITS))
					st = ST_FULL;
			end
			OP_F, OP_SU: begin
				if (arg_q > 32'd32 || (op_q == OP_SU && arg_q == 32'd0)) begin
					st = ST_BADARG;
				end else if (arg_q > fill32) begin
					st = ST_UNDER;
				end else if (arg_q != 32'd0) begin
					n = arg_q[6:0];
					v = peek64(front, 7'd0, n);
					if (op_q == OP_SU && v[n[5:0] - 6'd1])
						v = v - (64'd1 << n);
					val  = v;
					take = n;
				end
			end
			OP_NS: begin
				if (arg_q > 32'd1) begin
					w = 7'(6'd32 - clz32(arg_q));
					m = (64'd1 << w) - {32'd0, arg_q};
					if (32'(w - 7'd1) > fill32) begin
						st = ST_UNDER;
					end else begin
						v = peek64(front, 7'd0, w - 7'd1);
						if (v < m) begin
							val  = v;
							take = w - 7'd1;
						end else if (32'(w) > fill32) begin
							st = ST_UNDER;
						end else begin
							val  = (v << 1) - m + peek64(front, w - 7'd1, 7'd1);
							take = w;
						end
					end
				end
			end
			OP_LE: begin
				if (arg_q > 32'd4) begin
					st = ST_BADARG;
				end else if (32'({arg_q[2:0], 3'b000}) > fill32) begin
					st = ST_UNDER;
				end else begin
					for (int i = 0; i < 4; i++) begin
						if (32'(i) < arg_q)
							val = val | (64'(front[63-8*i -: 8]) << (8 * i));
					end
					take = {1'b0, arg_q[2:0], 3'b000};
				end
			end
			OP_UVLC: begin
				c  = clz32(front[63:32]);
				lz = (32'(c) > fill32) ? fill_q[5:0] : c;
				if (lz == 6'd32) begin
					val  = 64'hFFFF_FFFF;
					take = 7'd32;
				end else if (32'({lz, 1'b1}) > fill32) begin
					st = ST_UNDER;
				end else begin
					val  = ((64'd1 << lz) - 64'd1) + peek64(front, 7'(lz) + 7'd1, 7'(lz));
					take = {lz, 1'b1};
				end
			end
			OP_LEB: begin
				for (int k = 0; k < 8; k++) begin
					if (!stop) begin
						if (32'((k + 1) * 8) > fill32) begin
							stop = 1'b1;
						end else begin
							b   = front[63-8*k -: 8];
							val = val | (64'(b[6:0]) << (7 * k));
							cnt = cnt + 4'd1;
							if (!b[7]) begin
								done = 1'b1;
								stop = 1'b1;
							end
						end
					end
				end
				if (!done && cnt < 4'd8) begin
					st = ST_UNDER;
				end else begin
					len  = cnt;
					take = {cnt, 3'b000};
				end
			end
			default: ;
		endcase
		if (st != ST_OK) begin
			val  = 64'd0;
			len  = 4'd0;
			take = 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cons_q <= 32'd0;
		end else if (cmd.apply) begin
			if (op_q == OP_RESTART) begin
				fill_q <= '0;
				cons_q <= 32'd0;
			end else if (push_ok_q) begin
				fill_q <= fill_q + FW'(8);
			end else begin
				fill_q <= fill_q - FW'(take_q);
				cons_q <= res_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_opcode;
			byte_q <= in_byte;
			arg_q  <= in_arg;
		end
		if (cmd.calc) begin
			res_value  <= val[56:0];
			res_len    <= len;
			res_status <= st;
			res_pos    <= (op_q == OP_RESTART) ? 32'd0 : cons_q + 32'(take);
			take_q     <= take;
			push_ok_q  <= (op_q == OP_PUSH) && (st == ST_OK);
		end
		if (cmd.apply && op_q != OP_RESTART) begin
			if (push_ok_q)
				buf_q <= (buf_q & ~(BUFFER_BITS'(8'hFF) << shv))
					| (BUFFER_BITS'(byte_q) << shv);
			else
				buf_q <= buf_q << take_q;
		end
	end

endmodule

[design/av1_syntax_element_reader_unit.sv]
// From input transfer to result: decode (CALC), buffer update (APPLY), result offered (OUT).
// The controller runs one item at a time; a new request is taken only after the result transfer.
// Each element is decoded in CALC; the buffer shift or byte insert follows in the next cycle.
// Reset (arst_n low) empties the bit buffer and clears the consumed bit count.
// Buffer contents need no reset: only bits below the fill level are ever used.
`include "av1_syntax_element_reader_unit_assert.svh"

module av1_syntax_element_reader_unit #(
	parameter int BUFFER_BITS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] argument
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [56:0] value, [60:57] length_bytes,
	                               // [92:61] bit_position, [95:93] zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import avr_pkg::*;

	avr_cmd_t    cmd;
	logic [56:0] res_value;
	logic [3:0]  res_len;
	logic [31:0] res_pos;

	// Controller sequences load, decode, apply and output handoff
	avr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Datapath holds the bit buffer, fill level and the decoders
	avr_dp #(.BUFFER_BITS(BUFFER_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_opcode  (s_tuser),
		.in_byte    (s_tdata[7:0]),
		.in_arg     (s_tdata[39:8]),
		.res_value  (res_value),
		.res_len    (res_len),
		.res_status (m_tuser),
		.res_pos    (res_pos)
	);

	// Pack the held result; it stays stable while the transfer waits
	assign m_tdata = {3'b000, res_pos, res_len, res_value};

	`AVR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`AVR_ASSERT_NEXT(a_drop_after_out, m_tvalid && m_tready, !m_tvalid, "result repeated")
	`AVR_ASSERT_NOW(a_one_item, s_tready, !m_tvalid, "input open while result pending")
	`AVR_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser != ST_OK, m_tdata[60:0] == 61'd0, "error value")

endmodule
